// ===== hw/rtl/multi_target_best_cost_tracker_assert.svh =====
// Assertion macros for the best cost tracker
`ifndef MULTI_TARGET_BEST_COST_TRACKER_ASSERT_SVH
`define MULTI_TARGET_BEST_COST_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MTBCT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MTBCT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mtbct_pkg.sv =====
// Shared types, field layout and cost helpers for the best cost tracker
`default_nettype none

package mtbct_pkg;

   // Field widths
   localparam int FUNC_W     = 2;
   localparam int LOC_IN_W   = 20;
   localparam int DEST_IN_W  = 6;
   localparam int DUR_W      = 15;
   localparam int COST_W     = 16;
   localparam int STATUS_W   = 2;

   // Request tdata layout, lowest field first
   localparam int LOC_LSB    = 0;
   localparam int DEST_LSB   = LOC_LSB + LOC_IN_W;
   localparam int DUR_LSB    = DEST_LSB + DEST_IN_W;
   localparam int COST_LSB   = DUR_LSB + DUR_W;
   localparam int REQ_DATA_W = 64;

   // Response tdata: worst_cost, worst_dest, status
   localparam int RSP_DATA_W = COST_W + DEST_IN_W + STATUS_W;

   localparam logic signed [COST_W-1:0] INVALID_FWD = 16'sh7FFF;
   localparam logic signed [COST_W-1:0] INVALID_BWD = 16'sh8000;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_LOAD   = 2'd1,
      FUNC_UPDATE = 2'd2
   } mtbct_func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } mtbct_status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic do_clear;
      logic do_load;
      logic flag_full;
      logic scan_start;
      logic rescan_start;
      logic flag_miss;
      logic finish;
   } mtbct_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_clear;
      logic is_load;
      logic load_reject;
      logic is_update;
      logic scan_done;
      logic found;
      logic need_rescan;
      logic rescan_done;
      logic out_free;
   } mtbct_stat_type;

   function automatic logic signed [COST_W-1:0] invalid_of(input logic dir);
      return dir ? INVALID_BWD : INVALID_FWD;
   endfunction

   function automatic logic signed [COST_W-1:0] opposite_of(input logic dir);
      return dir ? INVALID_FWD : INVALID_BWD;
   endfunction

   // a is better than b under the given direction
   function automatic logic better(input logic dir,
                                   input logic signed [COST_W-1:0] a,
                                   input logic signed [COST_W-1:0] b);
      return dir ? (b < a) : (a < b);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/multi_target_best_cost_tracker.sv =====
// Top level of the multi-destination best cost tracker
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_tvalid/tready    tdata: location, dest_index, duration, cost
//                                            tuser: func
//   rsp      out        rsp_tvalid/tready    tdata: worst_cost, worst_dest, status
//   csr      in         csr_wr_en            csr_wr_data: direction
//
// One transaction is worked on at a time; the next is taken once the result is loaded.
// Clear or rejected load: no scan. Load: a rescan of all destinations for the new worst.
// Update: an entry scan, plus a rescan of all destinations when the worst destination
// improved; the single read ports of the entry table and best cost memory set the pace.
// Synchronous active-high reset; no clearing pass is needed after it.
// A stalled result is held in the output register while the next request is accepted.
`default_nettype none

`include "multi_target_best_cost_tracker_assert.svh"

module multi_target_best_cost_tracker
   import mtbct_pkg::*;
#(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DEST    = 64,
   parameter int LOC_BITS    = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [19:0] location, [25:20] dest_index, [40:26] duration, [56:41] cost, [63:57] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] func
   input  wire logic [FUNC_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] worst_cost, [21:16] worst_dest, [23:22] status
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data
);

   mtbct_cmd_type  cmd_w;
   mtbct_stat_type stat_w;

   // Sequencer
   mtbct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat_w),
      .cmd        (cmd_w)
   );

   // Tables and arithmetic
   mtbct_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_DEST    (MAX_DEST),
      .LOC_BITS    (LOC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd_w),
      .stat        (stat_w)
   );

   // Checks
   `MTBCT_ASSERT_NOW(a_ready_drained, req_tready, stat_w.scan_done && stat_w.rescan_done, "request taken while pipelines busy")
   `MTBCT_ASSERT_NOW(a_finish_free, cmd_w.finish, stat_w.out_free, "result loaded over pending result")
   `MTBCT_ASSERT_NEXT(a_finish_valid, cmd_w.finish, rsp_tvalid, "loaded result not presented")
   `MTBCT_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0({cmd_w.do_clear, cmd_w.do_load, cmd_w.scan_start, cmd_w.flag_full, cmd_w.flag_miss}), "conflicting datapath commands")

endmodule

`default_nettype wire

// ===== hw/rtl/mtbct_ctrl.sv =====
// Sequencing state machine for the best cost tracker
`default_nettype none

module mtbct_ctrl
   import mtbct_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire mtbct_stat_type stat,
   output mtbct_cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_RESCAN = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // No transaction is taken while reset is held
   assign req_tready = (state_ff == S_IDLE) && !reset;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_clear) begin
               cmd.do_clear = 1'b1;
               state_in     = S_FINISH;
            end else if (stat.is_load) begin
               if (stat.load_reject) begin
                  cmd.flag_full = 1'b1;
                  state_in      = S_FINISH;
               end else begin
                  cmd.do_load      = 1'b1;
                  cmd.rescan_start = 1'b1;
                  state_in         = S_RESCAN;
               end
            end else if (stat.is_update) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               if (!stat.found) begin
                  cmd.flag_miss = 1'b1;
                  state_in      = S_FINISH;
               end else if (stat.need_rescan) begin
                  cmd.rescan_start = 1'b1;
                  state_in         = S_RESCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_RESCAN: begin
            if (stat.rescan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mtbct_dp.sv =====
// Datapath: entry table, best cost memory, worst tracking and result register
`default_nettype none

module mtbct_dp
   import mtbct_pkg::*;
#(
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_DEST    = 64,
   parameter int LOC_BITS    = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [FUNC_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data,
   input  wire mtbct_cmd_type         cmd,
   output mtbct_stat_type             stat
);

   localparam int EA_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int EC_W  = $clog2(MAX_ENTRIES + 1);
   localparam int DA_W  = (MAX_DEST > 1) ? $clog2(MAX_DEST) : 1;
   localparam int DC_W  = $clog2(MAX_DEST + 1);
   localparam int ENT_W = LOC_BITS + DA_W + DUR_W;

   // Captured transaction
   logic [FUNC_W-1:0]        func_ff;
   logic [LOC_BITS-1:0]      loc_ff;
   logic [DEST_IN_W-1:0]     dest_ff;
   logic [DUR_W-1:0]         dur_ff;
   logic signed [COST_W-1:0] cost_ff;
   logic [31:0]              loc_wide;
   logic [31:0]              dest_wide;
   logic [DA_W-1:0]          dest_idx;

   // Control and table state
   logic                     dir_ff;
   logic [EC_W-1:0]          count_ff, count_in;
   logic [MAX_DEST-1:0]      reach_ff, reach_in;
   logic [MAX_DEST-1:0]      best_vld_ff, best_vld_in;
   logic signed [COST_W-1:0] clear_val_ff, clear_val_in;
   logic signed [COST_W-1:0] worst_val_ff, worst_val_in;
   logic [DA_W-1:0]          worst_idx_ff, worst_idx_in;
   mtbct_status_type         status_ff, status_in;

   // Entry scan pipeline
   logic                     scan_act_ff, scan_act_in;
   logic [EC_W-1:0]          idx_ff, idx_in;
   logic                     s1_vld_ff, s1_vld_in;
   logic [ENT_W-1:0]         ent_rd_ff;
   logic [MAX_DEST-1:0]      seen_ff, seen_in;
   logic                     found_ff, found_in;
   logic                     need_ff, need_in;
   logic                     s2_vld_ff, s2_vld_in;
   logic [DA_W-1:0]          s2_dst_ff;
   logic [DUR_W-1:0]         s2_dur_ff;
   logic [LOC_BITS-1:0]      ent_loc;
   logic [DA_W-1:0]          ent_dst;
   logic [DUR_W-1:0]         ent_dur;
   logic                     s1_hit;
   logic                     s1_new;

   // Best cost memory port
   logic signed [COST_W-1:0] best_mem [MAX_DEST];
   logic signed [COST_W-1:0] best_rd_ff;
   logic                     bval_rd_ff;
   logic [DA_W-1:0]          best_raddr;
   logic signed [COST_W-1:0] best_cur;
   logic signed [COST_W-1:0] dur_s;
   logic signed [COST_W-1:0] total;
   logic                     s2_win;

   // Rescan pipeline
   logic                     rs_act_ff, rs_act_in;
   logic [DC_W-1:0]          rs_idx_ff, rs_idx_in;
   logic                     rs_vld_ff, rs_vld_in;
   logic [DA_W-1:0]          rs_d_ff, rs_d_in;
   logic                     rs_win;

   // Entry memory
   logic [ENT_W-1:0]         ent_mem [MAX_ENTRIES];

   // Result register
   logic                     rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic [31:0]              worst_wide;

   // Unpack the request fields
   assign loc_wide  = 32'(req_tdata[LOC_LSB +: LOC_IN_W]);
   assign dest_wide = 32'(dest_ff);
   assign dest_idx  = dest_wide[DA_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_tuser;
         loc_ff  <= loc_wide[LOC_BITS-1:0];
         dest_ff <= req_tdata[DEST_LSB +: DEST_IN_W];
         dur_ff  <= req_tdata[DUR_LSB +: DUR_W];
         cost_ff <= req_tdata[COST_LSB +: COST_W];
      end
   end

   // Direction register
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= 1'b0;
      end else if (csr_wr_en) begin
         dir_ff <= csr_wr_data;
      end
   end

   // Entry table: written at the fill count, read at the scan index
   always_ff @(posedge clock) begin
      if (cmd.do_load) begin
         ent_mem[count_ff[EA_W-1:0]] <= {dur_ff, dest_idx, loc_ff};
      end
      ent_rd_ff <= ent_mem[idx_ff[EA_W-1:0]];
   end

   assign ent_loc = ent_rd_ff[LOC_BITS-1:0];
   assign ent_dst = ent_rd_ff[LOC_BITS +: DA_W];
   assign ent_dur = ent_rd_ff[LOC_BITS + DA_W +: DUR_W];
   assign s1_hit  = s1_vld_ff && (ent_loc == loc_ff);
   assign s1_new  = s1_hit && !seen_ff[ent_dst];

   // Best cost memory: one read port shared by scan and rescan
   assign best_raddr = rs_act_ff ? rs_idx_ff[DA_W-1:0] : ent_dst;

   always_ff @(posedge clock) begin
      if (s2_win) begin
         best_mem[s2_dst_ff] <= total;
      end
      best_rd_ff <= best_mem[best_raddr];
      bval_rd_ff <= best_vld_ff[best_raddr];
   end

   // Entries never improved since clear read as the cleared value
   assign best_cur = bval_rd_ff ? best_rd_ff : clear_val_ff;
   assign dur_s    = signed'({1'b0, s2_dur_ff});
   assign total    = dir_ff ? (cost_ff - dur_s) : (cost_ff + dur_s);
   assign s2_win   = s2_vld_ff && better(dir_ff, total, best_cur);
   assign rs_win   = rs_vld_ff && reach_ff[rs_d_ff] && better(dir_ff, worst_val_ff, best_cur);

   // Stage two capture
   always_ff @(posedge clock) begin
      if (s1_new) begin
         s2_dst_ff <= ent_dst;
         s2_dur_ff <= ent_dur;
      end
   end

   // Next-state logic for table, scan and rescan
   always_comb begin
      count_in     = count_ff;
      reach_in     = reach_ff;
      best_vld_in  = best_vld_ff;
      clear_val_in = clear_val_ff;
      worst_val_in = worst_val_ff;
      worst_idx_in = worst_idx_ff;
      status_in    = status_ff;
      scan_act_in  = scan_act_ff;
      idx_in       = idx_ff;
      s1_vld_in    = 1'b0;
      seen_in      = seen_ff;
      found_in     = found_ff;
      need_in      = need_ff;
      s2_vld_in    = s1_new;
      rs_act_in    = rs_act_ff;
      rs_idx_in    = rs_idx_ff;
      rs_vld_in    = 1'b0;
      rs_d_in      = rs_d_ff;
      rsp_vld_in   = rsp_vld_ff;

      if (cmd.capture) begin
         status_in = ST_OK;
      end
      if (cmd.flag_full) begin
         status_in = ST_FULL;
      end
      if (cmd.flag_miss) begin
         status_in = ST_MISS;
      end

      if (cmd.do_clear) begin
         count_in     = '0;
         reach_in     = '0;
         best_vld_in  = '0;
         clear_val_in = invalid_of(dir_ff);
         worst_val_in = opposite_of(dir_ff);
         worst_idx_in = '0;
      end

      if (cmd.do_load) begin
         count_in           = count_ff + 1'b1;
         reach_in[dest_idx] = 1'b1;
      end

      // Entry scan issue
      if (cmd.scan_start) begin
         scan_act_in = 1'b1;
         idx_in      = '0;
         seen_in     = '0;
         found_in    = 1'b0;
         need_in     = 1'b0;
      end else if (scan_act_ff) begin
         if (idx_ff < count_ff) begin
            s1_vld_in = 1'b1;
            idx_in    = idx_ff + 1'b1;
         end else begin
            scan_act_in = 1'b0;
         end
      end

      // Stage one: location match and first-entry filter
      if (s1_hit) begin
         found_in = 1'b1;
      end
      if (s1_new) begin
         seen_in[ent_dst] = 1'b1;
      end

      // Stage two: keep the better cost
      if (s2_win) begin
         best_vld_in[s2_dst_ff] = 1'b1;
         if (worst_idx_ff == s2_dst_ff) begin
            need_in = 1'b1;
         end
      end

      // Worst rescan over all destinations
      if (cmd.rescan_start) begin
         rs_act_in    = 1'b1;
         rs_idx_in    = '0;
         worst_val_in = opposite_of(dir_ff);
      end else if (rs_act_ff) begin
         if (rs_idx_ff < DC_W'(MAX_DEST)) begin
            rs_vld_in = 1'b1;
            rs_d_in   = rs_idx_ff[DA_W-1:0];
            rs_idx_in = rs_idx_ff + 1'b1;
         end else begin
            rs_act_in = 1'b0;
         end
      end
      if (rs_win) begin
         worst_val_in = best_cur;
         worst_idx_in = rs_d_ff;
      end

      // Result register
      if (cmd.finish) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         reach_ff     <= '0;
         best_vld_ff  <= '0;
         clear_val_ff <= invalid_of(1'b0);
         worst_val_ff <= opposite_of(1'b0);
         worst_idx_ff <= '0;
         status_ff    <= ST_OK;
         scan_act_ff  <= 1'b0;
         idx_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         need_ff      <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rs_act_ff    <= 1'b0;
         rs_idx_ff    <= '0;
         rs_vld_ff    <= 1'b0;
         rs_d_ff      <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         count_ff     <= count_in;
         reach_ff     <= reach_in;
         best_vld_ff  <= best_vld_in;
         clear_val_ff <= clear_val_in;
         worst_val_ff <= worst_val_in;
         worst_idx_ff <= worst_idx_in;
         status_ff    <= status_in;
         scan_act_ff  <= scan_act_in;
         idx_ff       <= idx_in;
         s1_vld_ff    <= s1_vld_in;
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         need_ff      <= need_in;
         s2_vld_ff    <= s2_vld_in;
         rs_act_ff    <= rs_act_in;
         rs_idx_ff    <= rs_idx_in;
         rs_vld_ff    <= rs_vld_in;
         rs_d_ff      <= rs_d_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Result payload
   assign worst_wide = 32'(worst_idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {status_ff, worst_wide[DEST_IN_W-1:0], worst_val_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status to the controller
   assign stat.is_clear    = (func_ff == FUNC_CLEAR);
   assign stat.is_load     = (func_ff == FUNC_LOAD);
   assign stat.load_reject = (32'(count_ff) >= 32'(MAX_ENTRIES))
                             || (32'(dest_ff) >= 32'(MAX_DEST));
   assign stat.is_update   = (func_ff == FUNC_UPDATE) && (cost_ff != invalid_of(dir_ff));
   assign stat.scan_done   = !scan_act_ff && !s1_vld_ff && !s2_vld_ff;
   assign stat.found       = found_ff;
   assign stat.need_rescan = need_ff;
   assign stat.rescan_done = !rs_act_ff && !rs_vld_ff;
   assign stat.out_free    = !rsp_vld_ff || rsp_tready;

endmodule

`default_nettype wire
